// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the substring search block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define SSF_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Expression must never be true outside reset.
`define SSF_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");

`else

`define SSF_ASSERT(label, clk, rst_n, prop)
`define SSF_NEVER(label, clk, rst_n, expr)

`endif

`endif

// File: hw/rtl/ssf_pkg.sv
// Package for the substring search block: register codes, widths, case folding.
`default_nettype none

package ssf_pkg;

    // Fixed field widths
    localparam int POS_OUT_W     = 24;
    localparam int PATTERN_BYTES = 32;
    localparam int CFG_DATA_W    = 64;
    localparam int CFG_ADDR_W    = 6;
    localparam int CFG_LEN_W     = 6;
    localparam int WORD_BYTES    = 8;

    // Register index, taken from paddr[5:3]
    typedef logic [2:0] t_reg_idx;

    localparam t_reg_idx REG_PATTERN_LENGTH = 3'd0;
    localparam t_reg_idx REG_CASE_SENSITIVE = 3'd1;
    localparam t_reg_idx REG_PATTERN_WORD_0 = 3'd2;
    localparam t_reg_idx REG_PATTERN_WORD_1 = 3'd3;
    localparam t_reg_idx REG_PATTERN_WORD_2 = 3'd4;
    localparam t_reg_idx REG_PATTERN_WORD_3 = 3'd5;

    // ASCII constants for folding
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;

    // Fold a-z to upper case when folding is on
    function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic fold_on);
        logic [7:0] res;
        res = c;
        if (fold_on && c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
            res = c - (CHAR_LOWER_A - CHAR_UPPER_A);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/ssf_if.sv
// Channel interfaces of the substring search block: text requests and results.
`default_nettype none

interface ssf_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       byte_present;
    logic       end_of_text;

    modport source (output valid, output text_byte, output byte_present,
                    output end_of_text, input ready);
    modport sink   (input valid, input text_byte, input byte_present,
                    input end_of_text, output ready);
endinterface

interface ssf_result_if;
    logic                          valid;
    logic                          ready;
    logic                          found;
    logic [ssf_pkg::POS_OUT_W-1:0] match_position;

    modport source (output valid, output found, output match_position, input ready);
    modport sink   (input valid, input found, input match_position, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/substring_search_case_fold_top.sv
// Top level of the streaming first-match substring search with case folding.
//
//   channel    dir  handshake         payload
//   i_text     in   valid/ready       text_byte, byte_present, end_of_text
//   o_result   out  valid/ready       found, match_position
//   APB cfg    in   psel/penable      paddr, pwdata (64 bit), prdata
//
// One text request is taken every cycle; the window compare is a single
// registered pass between the input register and the result register.
// A result is registered in the result register when its end-of-text item leaves the input register.
// Reset is synchronous, active low; no clearing pass is needed.
// Only an end-of-text request waiting on a full result register stalls input.
`default_nettype none
`include "assert_macros.svh"

module substring_search_case_fold_top #(
    parameter int MAX_PATTERN   = 32,
    parameter int POSITION_BITS = 24
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    ssf_text_if.sink                         i_text,
    ssf_result_if.source                     o_result,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [ssf_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [ssf_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [ssf_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                             pready
);

    localparam int LEN_W    = $clog2(MAX_PATTERN + 1);
    localparam int WIN_BITS = 8 * MAX_PATTERN;
    localparam logic [LEN_W-1:0]         MAX_LEN = LEN_W'(MAX_PATTERN);
    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

    // ---------------- configuration registers ----------------
    logic [ssf_pkg::CFG_LEN_W-1:0]  r_pat_len;
    logic                           r_case_sens;
    logic [ssf_pkg::CFG_DATA_W-1:0] r_pat_word [4];

    ssf_pkg::t_reg_idx cfg_idx;
    logic              cfg_wr;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[5:3];
    assign cfg_wr  = psel & penable & pwrite;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_len   <= '0;
            r_case_sens <= 1'b1;
            for (int w = 0; w < 4; w++) begin
                r_pat_word[w] <= '0;
            end
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                ssf_pkg::REG_PATTERN_LENGTH: r_pat_len   <= pwdata[ssf_pkg::CFG_LEN_W-1:0];
                ssf_pkg::REG_CASE_SENSITIVE: r_case_sens <= pwdata[0];
                ssf_pkg::REG_PATTERN_WORD_0: r_pat_word[0] <= pwdata;
                ssf_pkg::REG_PATTERN_WORD_1: r_pat_word[1] <= pwdata;
                ssf_pkg::REG_PATTERN_WORD_2: r_pat_word[2] <= pwdata;
                ssf_pkg::REG_PATTERN_WORD_3: r_pat_word[3] <= pwdata;
                default: ;
            endcase
        end
    end

    // Register reads
    always_comb begin
        unique case (cfg_idx)
            ssf_pkg::REG_PATTERN_LENGTH: prdata = ssf_pkg::CFG_DATA_W'(r_pat_len);
            ssf_pkg::REG_CASE_SENSITIVE: prdata = ssf_pkg::CFG_DATA_W'(r_case_sens);
            ssf_pkg::REG_PATTERN_WORD_0: prdata = r_pat_word[0];
            ssf_pkg::REG_PATTERN_WORD_1: prdata = r_pat_word[1];
            ssf_pkg::REG_PATTERN_WORD_2: prdata = r_pat_word[2];
            ssf_pkg::REG_PATTERN_WORD_3: prdata = r_pat_word[3];
            default:                     prdata = '0;
        endcase
    end

    // ---------------- effective length and aligned pattern ----------------
    logic [LEN_W-1:0]    len_u;
    logic [LEN_W-1:0]    sh_amt;
    logic [7:0]          pat_b [MAX_PATTERN];
    logic [WIN_BITS-1:0] pat_rev;
    logic [WIN_BITS-1:0] pat_aln;
    logic                fold_on;

    assign fold_on = ~r_case_sens;

    // Lengths above the window size clamp to the window size
    always_comb begin
        if ({1'b0, r_pat_len} > 7'(MAX_PATTERN)) begin
            len_u = MAX_LEN;
        end else begin
            len_u = LEN_W'(r_pat_len);
        end
    end

    // Pattern bytes past the four words read as zero
    for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_pat
        if (k < ssf_pkg::PATTERN_BYTES) begin : g_real
            assign pat_b[k] = r_pat_word[k / ssf_pkg::WORD_BYTES]
                                        [8 * (k % ssf_pkg::WORD_BYTES) +: 8];
        end else begin : g_zero
            assign pat_b[k] = 8'h00;
        end
        assign pat_rev[8 * k +: 8] = pat_b[MAX_PATTERN - 1 - k];
    end

    // Window entry j (newest at 0) lines up with pattern byte len-1-j
    assign sh_amt  = MAX_LEN - len_u;
    assign pat_aln = pat_rev >> {sh_amt, 3'b000};

    // ---------------- input register ----------------
    logic       r_in_vld;
    logic [7:0] r_in_byte;
    logic       r_in_present;
    logic       r_in_eot;
    logic       s_go;
    logic       in_acc;

    // An item moves on unless it is an end item facing a full result register
    assign s_go         = r_in_vld & (~r_in_eot | ~o_result.valid | o_result.ready);
    assign i_text.ready = ~r_in_vld | s_go;
    assign in_acc       = i_text.valid & i_text.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= in_acc | (r_in_vld & ~s_go);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in_byte    <= i_text.text_byte;
            r_in_present <= i_text.byte_present;
            r_in_eot     <= i_text.end_of_text;
        end
    end

    // ---------------- window and per-text state ----------------
    logic [7:0]               r_win [MAX_PATTERN];
    logic [7:0]               n_win [MAX_PATTERN];
    logic [POSITION_BITS-1:0] r_seen;
    logic [POSITION_BITS-1:0] n_seen;
    logic [POSITION_BITS-1:0] seen_inc;
    logic                     r_latched;
    logic                     n_latched;
    logic [POSITION_BITS-1:0] r_start;
    logic [POSITION_BITS-1:0] n_start;
    logic [POSITION_BITS-1:0] len_pos;
    logic [MAX_PATTERN-1:0]   ok;
    logic                     hit;
    logic                     len_zero;

    // Shifted window with the new byte in front
    assign n_win[0] = r_in_byte;
    for (genvar j = 1; j < MAX_PATTERN; j++) begin : g_shift
        assign n_win[j] = r_win[j - 1];
    end

    // Per-entry compare; entries beyond the pattern length always agree
    for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cmp
        assign ok[j] = (LEN_W'(j) >= len_u) ||
                       (ssf_pkg::fold_byte(n_win[j], fold_on) ==
                        ssf_pkg::fold_byte(pat_aln[8 * j +: 8], fold_on));
    end

    assign len_zero = (len_u == '0);
    assign len_pos  = POSITION_BITS'(len_u);
    assign seen_inc = (r_seen == POS_MAX) ? r_seen : r_seen + 1'b1;
    assign hit      = r_in_present & ~r_latched & ~len_zero &
                      (seen_inc >= len_pos) & (&ok);

    assign n_seen    = r_in_present ? seen_inc : r_seen;
    assign n_latched = r_latched | hit;
    assign n_start   = hit ? seen_inc - len_pos : r_start;

    always_ff @(posedge i_clk) begin
        if (s_go && r_in_present) begin
            r_win <= n_win;
        end
    end

    // Counter and match latch clear after each end item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen    <= '0;
            r_latched <= 1'b0;
            r_start   <= '0;
        end else if (s_go) begin
            if (r_in_eot) begin
                r_seen    <= '0;
                r_latched <= 1'b0;
                r_start   <= '0;
            end else begin
                r_seen    <= n_seen;
                r_latched <= n_latched;
                r_start   <= n_start;
            end
        end
    end

    // ---------------- result register ----------------
    logic                          r_out_vld;
    logic                          r_out_found;
    logic [ssf_pkg::POS_OUT_W-1:0] r_out_pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s_go && r_in_eot) begin
            r_out_vld <= 1'b1;
        end else if (o_result.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_go && r_in_eot) begin
            r_out_found <= len_zero | n_latched;
            if (len_zero || !n_latched) begin
                r_out_pos <= '0;
            end else begin
                r_out_pos <= ssf_pkg::POS_OUT_W'(n_start);
            end
        end
    end

    assign o_result.valid          = r_out_vld;
    assign o_result.found          = r_out_found;
    assign o_result.match_position = r_out_pos;

    // ---------------- assertions ----------------
    `SSF_ASSERT(a_stall_only_full, i_clk, i_rst_n, !i_text.ready |-> (r_in_vld && r_in_eot && o_result.valid))
    `SSF_ASSERT(a_start_in_text, i_clk, i_rst_n, r_latched |-> (r_start <= r_seen))
    `SSF_ASSERT(a_clear_after_end, i_clk, i_rst_n, (s_go && r_in_eot) |=> (r_seen == '0 && !r_latched))
    `SSF_NEVER(a_pos_without_found, i_clk, i_rst_n, o_result.valid && !o_result.found && (o_result.match_position != '0))

endmodule

`default_nettype wire

// File: tb/ssf_search_checker.sv
// Scoreboard for the substring search block: tracks registers, predicts results, compares.
`timescale 1ns / 100ps

module ssf_search_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    ssf_text_if                            text_tap,
    ssf_result_if                          result_tap,
    input  logic                           i_psel,
    input  logic                           i_penable,
    input  logic                           i_pwrite,
    input  logic                           i_pready,
    input  logic [ssf_pkg::CFG_ADDR_W-1:0] i_paddr,
    input  logic [ssf_pkg::CFG_DATA_W-1:0] i_pwdata,
    output int                             o_mismatches,
    output int                             o_pending
);

    localparam int                SEEN_W   = 24;
    localparam logic [SEEN_W-1:0] SEEN_MAX = '1;

    typedef struct packed {
        logic                          found;
        logic [ssf_pkg::POS_OUT_W-1:0] position;
    } t_search_verdict;

    // Shadow copy of the registers
    logic [ssf_pkg::CFG_LEN_W-1:0]  cfg_len;
    logic                           cfg_exact;
    logic [ssf_pkg::CFG_DATA_W-1:0] cfg_words [4];

    // Per-text search state
    logic [7:0]        window_q [ssf_pkg::PATTERN_BYTES];
    logic [SEEN_W-1:0] seen_q;
    logic              hit_q;
    logic [SEEN_W-1:0] hit_start_q;

    t_search_verdict pending_verdicts [$];
    int              fault_count;

    // Upper-case a letter when folding is on; a-z and A-Z differ only in bit 5
    function automatic logic [7:0] upcase(input logic [7:0] c);
        if (!cfg_exact && c >= ssf_pkg::CHAR_LOWER_A && c <= ssf_pkg::CHAR_LOWER_Z) begin
            return c & 8'hDF;
        end
        return c;
    endfunction

    function automatic int active_len();
        return (cfg_len > ssf_pkg::PATTERN_BYTES) ? ssf_pkg::PATTERN_BYTES : int'(cfg_len);
    endfunction

    task automatic clear_text();
        foreach (window_q[i]) window_q[i] = '0;
        seen_q      = '0;
        hit_q       = 1'b0;
        hit_start_q = '0;
    endtask

    task automatic apply_write(input ssf_pkg::t_reg_idx idx,
                               input logic [ssf_pkg::CFG_DATA_W-1:0] value);
        case (idx)
            ssf_pkg::REG_PATTERN_LENGTH: cfg_len      = value[ssf_pkg::CFG_LEN_W-1:0];
            ssf_pkg::REG_CASE_SENSITIVE: cfg_exact    = value[0];
            ssf_pkg::REG_PATTERN_WORD_0: cfg_words[0] = value;
            ssf_pkg::REG_PATTERN_WORD_1: cfg_words[1] = value;
            ssf_pkg::REG_PATTERN_WORD_2: cfg_words[2] = value;
            ssf_pkg::REG_PATTERN_WORD_3: cfg_words[3] = value;
            default: ;   // unmapped index, ignored
        endcase
    endtask

    // Shift one text request through the window and queue the verdict at end of text
    task automatic predict_search_step(input logic [7:0] b, input logic present,
                                       input logic last);
        int              n;
        bit              same;
        t_search_verdict verdict;
        n = active_len();
        if (present) begin
            for (int i = ssf_pkg::PATTERN_BYTES - 1; i > 0; i--) window_q[i] = window_q[i-1];
            window_q[0] = b;
            if (seen_q != SEEN_MAX) seen_q++;
            if (!hit_q && n > 0 && seen_q >= n) begin
                same = 1'b1;
                for (int k = 0; k < n; k++) begin
                    if (upcase(window_q[n-1-k]) !=
                        upcase(cfg_words[k / ssf_pkg::WORD_BYTES]
                                        [(k % ssf_pkg::WORD_BYTES) * 8 +: 8])) begin
                        same = 1'b0;
                    end
                end
                if (same) begin
                    hit_q       = 1'b1;
                    hit_start_q = seen_q - SEEN_W'(n);
                end
            end
        end
        if (last) begin
            verdict.found    = (n == 0) || hit_q;
            verdict.position = (n != 0 && hit_q) ? hit_start_q[ssf_pkg::POS_OUT_W-1:0] : '0;
            pending_verdicts.push_back(verdict);
            clear_text();
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_search_verdict oldest;
        bit              bad;
        if (!i_rst_n) begin
            cfg_len   = '0;
            cfg_exact = 1'b1;
            foreach (cfg_words[w]) cfg_words[w] = '0;
            clear_text();
            pending_verdicts.delete();
            fault_count = 0;
        end else begin
            // register write on the access phase
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                apply_write(ssf_pkg::t_reg_idx'(i_paddr[ssf_pkg::CFG_ADDR_W-1:3]), i_pwdata);
            end
            if (text_tap.valid && text_tap.ready) begin
                predict_search_step(text_tap.text_byte, text_tap.byte_present,
                                    text_tap.end_of_text);
            end
            // compare each result with the oldest verdict
            if (result_tap.valid && result_tap.ready) begin
                if (pending_verdicts.size() == 0) begin
                    $display("%0t: unexpected result found=%0b position=%0d", $time,
                             result_tap.found, result_tap.match_position);
                    fault_count++;
                end else begin
                    oldest = pending_verdicts.pop_front();
                    bad    = 1'b0;
                    if (result_tap.found !== oldest.found) begin
                        $display("%0t: found mismatch, expected %0b, got %0b", $time,
                                 oldest.found, result_tap.found);
                        bad = 1'b1;
                    end
                    if (result_tap.match_position !== oldest.position) begin
                        $display("%0t: match_position mismatch, expected %0d, got %0d",
                                 $time, oldest.position, result_tap.match_position);
                        bad = 1'b1;
                    end
                    if (bad) fault_count++;
                end
            end
        end
        o_mismatches <= fault_count;
        o_pending    <= pending_verdicts.size();
    end

endmodule

// File: tb/tb.sv
// Testbench top for the substring search block: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb;

    localparam ssf_pkg::t_reg_idx REG_SPARE_LO = 3'd6;
    localparam ssf_pkg::t_reg_idx REG_SPARE_HI = 3'd7;
    localparam int IDLE_PCT      = 36;
    localparam int TARGET_ITEMS  = 1650;
    localparam int PHASE_ITEMS   = 118;
    localparam int SETTLE_CYCLES = 4;
    localparam int STEADY_PHASE  = 5;
    localparam logic [ssf_pkg::CFG_LEN_W-1:0] LEN_PLAN [14] =
        '{1, 2, 3, 32, 0, 8, 63, 5, 16, 33, 31, 9, 4, 1};

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           psel, penable, pwrite, pready;
    logic [ssf_pkg::CFG_ADDR_W-1:0] paddr;
    logic [ssf_pkg::CFG_DATA_W-1:0] pwdata, prdata;
    int                             mismatches, pending;

    bit                             steady;       // no idling on either side
    int                             text_items;
    logic [ssf_pkg::CFG_LEN_W-1:0]  cur_len;
    logic                           cur_exact;
    logic [7:0]                     pat_img [ssf_pkg::PATTERN_BYTES];

    ssf_text_if   text_ch ();
    ssf_result_if result_ch ();

    substring_search_case_fold_top dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_text   (text_ch),
        .o_result (result_ch),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    ssf_search_checker score_u (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .text_tap     (text_ch),
        .result_tap   (result_ch),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs
    initial begin
        #2_000_000;
        $display("tb: done, errors");
        $finish;
    end

    // Result side stalls at random
    initial result_ch.ready = 1'b0;
    always @(posedge i_clk) begin
        result_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    // One text request, with random idle cycles ahead of it
    task automatic send_text(input logic [7:0] b, input logic present, input logic last);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            text_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        text_ch.valid        <= 1'b1;
        text_ch.text_byte    <= b;
        text_ch.byte_present <= present;
        text_ch.end_of_text  <= last;
        do @(posedge i_clk); while (!text_ch.ready);
        if (present || last) text_items++;
    endtask

    task automatic send_str(input string s);
        for (int i = 0; i < s.len(); i++) send_text(s[i], 1'b1, i == s.len() - 1);
    endtask

    // APB write: setup cycle, then access cycle until pready
    task automatic write_reg(input ssf_pkg::t_reg_idx idx,
                             input logic [ssf_pkg::CFG_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Wait until every result is out and the pipeline is quiet
    task automatic drain();
        text_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Program length, case mode and all pattern words from pat_img
    task automatic load_search(input logic [ssf_pkg::CFG_LEN_W-1:0] len, input logic exact);
        logic [ssf_pkg::CFG_DATA_W-1:0] word;
        drain();
        cur_len   = len;
        cur_exact = exact;
        word = {$urandom, $urandom};
        word[ssf_pkg::CFG_LEN_W-1:0] = len;
        write_reg(ssf_pkg::REG_PATTERN_LENGTH, word);
        word = {$urandom, $urandom};
        word[0] = exact;
        write_reg(ssf_pkg::REG_CASE_SENSITIVE, word);
        for (int w = 0; w < 4; w++) begin
            for (int k = 0; k < ssf_pkg::WORD_BYTES; k++) begin
                word[k*8 +: 8] = pat_img[w*ssf_pkg::WORD_BYTES + k];
            end
            write_reg(ssf_pkg::t_reg_idx'(ssf_pkg::REG_PATTERN_WORD_0 + w), word);
        end
    endtask

    // Pattern from a string, zeros up to len, junk in the unused bytes
    task automatic set_pattern(input string s, input logic [ssf_pkg::CFG_LEN_W-1:0] len,
                               input logic exact);
        foreach (pat_img[k]) begin
            pat_img[k] = (k < s.len()) ? s[k] : ((k < len) ? 8'h00 : 8'($urandom));
        end
        load_search(len, exact);
    endtask

    // Small alphabet so that matches happen, mixed with arbitrary bytes
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(9))
            0, 1:    return "a";
            2, 3:    return "A";
            4:       return "b";
            5:       return "B";
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] maybe_flip(input logic [7:0] c);
        if (!cur_exact && $urandom_range(1) == 1 &&
            ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z"))) begin
            return c ^ 8'h20;
        end
        return c;
    endfunction

    // One text: mostly with the pattern planted, some near misses, some plain noise
    task automatic send_random_text();
        logic [7:0] body [$];
        int         n, span, at, style, spot;
        bit         end_marker;
        span  = (cur_len > ssf_pkg::PATTERN_BYTES) ? ssf_pkg::PATTERN_BYTES : int'(cur_len);
        n     = ($urandom_range(19) == 0) ? $urandom_range(40, 120) : $urandom_range(0, 24);
        style = $urandom_range(99);
        for (int i = 0; i < n; i++) body.push_back(pick_byte());
        if (style < 80 && span > 0) begin
            at = $urandom_range(n);
            for (int k = 0; k < span; k++) begin
                if (at + k == body.size()) body.push_back(8'h00);
                body[at + k] = maybe_flip(pat_img[k]);
            end
            // near miss: one byte off by its low bit
            if (style >= 65) begin
                spot       = at + $urandom_range(span - 1);
                body[spot] = body[spot] ^ 8'h01;
            end
        end
        end_marker = (body.size() == 0) || ($urandom_range(3) == 0);
        foreach (body[i]) begin
            if ($urandom_range(24) == 0) send_text(8'($urandom), 1'b0, 1'b0);
            send_text(body[i], 1'b1, !end_marker && i == body.size() - 1);
        end
        if (end_marker) send_text(8'($urandom), 1'b0, 1'b1);
    endtask

    initial begin : stimulus
        int phase;
        int phase_start;
        logic [ssf_pkg::CFG_LEN_W-1:0] len;
        i_rst_n              <= 1'b0;
        psel                 <= 1'b0;
        penable              <= 1'b0;
        pwrite               <= 1'b0;
        paddr                <= '0;
        pwdata               <= '0;
        text_ch.valid        <= 1'b0;
        text_ch.text_byte    <= '0;
        text_ch.byte_present <= 1'b0;
        text_ch.end_of_text  <= 1'b0;
        steady     = 1'b0;
        text_items = 0;
        cur_len    = '0;
        cur_exact  = 1'b1;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty pattern after reset: always found at 0, empty text too
        send_text(8'h00, 1'b0, 1'b1);
        send_text(8'h5A, 1'b0, 1'b0);   // idle request, no effect
        send_str("az");

        // writes to unmapped indexes must not disturb anything
        drain();
        write_reg(REG_SPARE_LO, {$urandom, $urandom});
        write_reg(REG_SPARE_HI, {$urandom, $urandom});

        // zero pattern vs cleared window: no hit until enough bytes came
        set_pattern("", 2, 1'b1);
        send_text(8'h00, 1'b1, 1'b1);
        send_text(8'h00, 1'b1, 1'b0);
        send_text(8'h00, 1'b1, 1'b1);

        // case folding, and an empty text with a real pattern
        set_pattern("a", 1, 1'b0);
        send_str("A");
        send_text(8'h00, 1'b1, 1'b0);
        send_str("Za");
        send_text(8'hFF, 1'b0, 1'b1);

        // bytes just outside a-z must not fold (grave accent, open brace)
        set_pattern("@", 1, 1'b0);
        send_text(8'h60, 1'b1, 1'b0);
        send_text(8'h7B, 1'b1, 1'b1);

        // exact compare, first match latched
        set_pattern("aBc", 3, 1'b1);
        send_str("abcaBc");
        send_text(8'hFF, 1'b1, 1'b1);

        // random phases, each with its own register setting
        phase = 0;
        while (text_items < TARGET_ITEMS) begin
            if (phase < $size(LEN_PLAN)) len = LEN_PLAN[phase];
            else len = ssf_pkg::CFG_LEN_W'($urandom_range(63));
            foreach (pat_img[k]) pat_img[k] = pick_byte();
            load_search(len, (phase < $size(LEN_PLAN)) ? phase[0] : 1'($urandom_range(1)));
            steady      = (phase == STEADY_PHASE);
            phase_start = text_items;
            while (text_items - phase_start < PHASE_ITEMS) send_random_text();
            phase++;
        end

        drain();
        if (mismatches == 0 && pending == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule
